FILE: rtl/gm3_pkg.sv
// Shared types, constants and helpers for the 3x3 gray morphology block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package gm3_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;

	localparam int PIX_W = 8;
	localparam int CFG_W = 11;

	// counter and dimension widths
	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int ROW_W  = $clog2(MAX_HEIGHT + 3);
	localparam int OROW_W = $clog2(MAX_HEIGHT + 1);
	localparam int WDIM_W = $clog2(MAX_WIDTH + 1);
	localparam int HDIM_W = $clog2(MAX_HEIGHT + 1);
	localparam int LAG_W  = $clog2(MAX_WIDTH + 2);
	localparam int CMP_W0 = $clog2(MAX_WIDTH + MAX_HEIGHT + 4) + 1;
	localparam int CMP_W  = (CMP_W0 > CFG_W) ? CMP_W0 : CFG_W + 1;

	// line store entry: {upper row pixel, lower row pixel}
	localparam int RAM_W = 2 * PIX_W;

	// output queue, depth a power of two
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		CFG_IMAGE_WIDTH  = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1,
		CFG_OPERATION    = 2'd2
	} cfg_reg_t;

	typedef enum logic {
		OP_ERODE  = 1'b0,
		OP_DILATE = 1'b1
	} op_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             is_pixel;
	} pixel_in_t;

	typedef struct packed {
		logic [PIX_W-1:0] result_value;
		logic             last_of_frame;
	} result_out_t;

	// one accepted tick on its way from the counters to the window
	typedef struct packed {
		logic             valid;
		logic [COL_W-1:0] col;
		logic [PIX_W-1:0] cur;
		logic             emit;
		logic [2:0]       row_ok;
		logic [2:0]       col_ok;
		logic             last;
	} tick_t;

	function automatic logic [WDIM_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
		if (v == '0)
			return WDIM_W'(1);
		if (CMP_W'(v) > CMP_W'(MAX_WIDTH))
			return WDIM_W'(MAX_WIDTH);
		return WDIM_W'(v);
	endfunction

	function automatic logic [HDIM_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
		if (v == '0)
			return HDIM_W'(1);
		if (CMP_W'(v) > CMP_W'(MAX_HEIGHT))
			return HDIM_W'(MAX_HEIGHT);
		return HDIM_W'(v);
	endfunction

endpackage

`default_nettype wire

FILE: rtl/gm3_line_store.sv
// Two-row line store: one synchronous RAM, one read and one write port.
// Read data registered; a write to the address being read is forwarded. Uses gm3_pkg.
`default_nettype none

module gm3_line_store
	import gm3_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [COL_W-1:0] waddr,
	input  wire logic [RAM_W-1:0] wdata,
	input  wire logic             re,
	input  wire logic [COL_W-1:0] raddr,
	output logic      [RAM_W-1:0] rdata
);

	logic [RAM_W-1:0] mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re) begin
			// same column back to back: take the data being written
			if (we && (waddr == raddr))
				rdata <= wdata;
			else
				rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/gm3_ctrl.sv
// Configuration registers and raster position counters.
// Decides per input tick whether it counts, where it sits and what it emits. Uses gm3_pkg.
`default_nettype none

module gm3_ctrl
	import gm3_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             in_fire,
	input  wire pixel_in_t        in_data,
	output logic                  rd_en,
	output logic      [COL_W-1:0] rd_addr,
	output tick_t                 tick_s1,
	output op_t                   op
);

	localparam logic [CMP_W-1:0] ONE_C = CMP_W'(1);
	localparam logic [CMP_W-1:0] TWO_C = CMP_W'(2);

	logic [WDIM_W-1:0] w_q;
	logic [HDIM_W-1:0] h_q;
	op_t               op_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  in_row_q;
	logic [COL_W-1:0]  ocol_q;
	logic [OROW_W-1:0] orow_q;
	logic [LAG_W-1:0]  lag_q;

	logic [CMP_W-1:0] w_c;
	logic [CMP_W-1:0] h_c;
	logic             in_frame;
	logic             eff;
	logic             col_last;
	logic             row_grow;
	logic             lag_full;
	logic             ocol_last;
	logic             orow_last;
	logic             frame_last;

	always_comb begin
		w_c        = CMP_W'(w_q);
		h_c        = CMP_W'(h_q);
		in_frame   = CMP_W'(in_row_q) < h_c;
		// a flush tick while pixels are still due is dropped
		eff        = in_fire && !(in_frame && !in_data.is_pixel);
		col_last   = (CMP_W'(col_q) + ONE_C) >= w_c;
		row_grow   = CMP_W'(in_row_q) < (h_c + TWO_C);
		lag_full   = CMP_W'(lag_q) >= (w_c + ONE_C);
		ocol_last  = (CMP_W'(ocol_q) + ONE_C) >= w_c;
		orow_last  = (CMP_W'(orow_q) + ONE_C) >= h_c;
		frame_last = ocol_last && orow_last;
		rd_en      = eff;
		rd_addr    = col_q;
		op         = op_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q      <= WDIM_W'(MAX_WIDTH);
			h_q      <= HDIM_W'(MAX_HEIGHT);
			op_q     <= OP_ERODE;
			col_q    <= '0;
			in_row_q <= '0;
			ocol_q   <= '0;
			orow_q   <= '0;
			lag_q    <= '0;
			tick_s1  <= '0;
		end else begin
			tick_s1.valid <= eff;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH: begin
						w_q      <= clamp_width(cfg_data);
						col_q    <= '0;
						in_row_q <= '0;
						ocol_q   <= '0;
						orow_q   <= '0;
						lag_q    <= '0;
					end
					CFG_IMAGE_HEIGHT: begin
						h_q      <= clamp_height(cfg_data);
						col_q    <= '0;
						in_row_q <= '0;
						ocol_q   <= '0;
						orow_q   <= '0;
						lag_q    <= '0;
					end
					CFG_OPERATION: begin
						op_q     <= op_t'(cfg_data[0]);
						col_q    <= '0;
						in_row_q <= '0;
						ocol_q   <= '0;
						orow_q   <= '0;
						lag_q    <= '0;
					end
					default: begin
					end
				endcase
			end else if (eff) begin
				tick_s1.col    <= col_q;
				tick_s1.cur    <= in_frame ? in_data.pixel : '0;
				tick_s1.emit   <= lag_full;
				tick_s1.last   <= frame_last;
				tick_s1.row_ok <= {!orow_last, 1'b1, orow_q != '0};
				tick_s1.col_ok <= {!ocol_last, 1'b1, ocol_q != '0};

				if (col_last) begin
					col_q <= '0;
					if (row_grow)
						in_row_q <= in_row_q + ROW_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end

				if (!lag_full) begin
					lag_q <= lag_q + LAG_W'(1);
				end else if (frame_last) begin
					// frame done: start over on the next tick
					col_q    <= '0;
					in_row_q <= '0;
					ocol_q   <= '0;
					orow_q   <= '0;
					lag_q    <= '0;
				end else if (ocol_last) begin
					ocol_q <= '0;
					orow_q <= orow_q + OROW_W'(1);
				end else begin
					ocol_q <= ocol_q + COL_W'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

FILE: rtl/gm3_window.sv
// 3x3 window registers and the masked min/max reduction.
// Takes a tick plus the two line store pixels; gives one result request. Uses gm3_pkg.
`default_nettype none

module gm3_window
	import gm3_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire tick_t            tick_s1,
	input  wire logic [PIX_W-1:0] up,
	input  wire logic [PIX_W-1:0] mid,
	input  wire op_t              op,
	output logic                  valid_s2,
	output logic                  push,
	output result_out_t           push_data
);

	logic [PIX_W-1:0] win_q [3][3];
	logic             emit_s2;
	logic             last_s2;
	logic [2:0]       row_ok_s2;
	logic [2:0]       col_ok_s2;

	logic [PIX_W-1:0] fill;
	logic [PIX_W-1:0] cellv [3][3];
	logic [PIX_W-1:0] rowv [3];
	logic [PIX_W-1:0] acc;

	function automatic logic [PIX_W-1:0] pick(input logic [PIX_W-1:0] a,
	                                          input logic [PIX_W-1:0] b,
	                                          input op_t o);
		if (o == OP_DILATE)
			return (a > b) ? a : b;
		return (a < b) ? a : b;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++)
				for (int c = 0; c < 3; c++)
					win_q[r][c] <= '0;
			valid_s2  <= 1'b0;
			emit_s2   <= 1'b0;
			last_s2   <= 1'b0;
			row_ok_s2 <= '0;
			col_ok_s2 <= '0;
		end else begin
			valid_s2 <= tick_s1.valid;
			if (tick_s1.valid) begin
				// advance one column, newest on the right
				for (int r = 0; r < 3; r++) begin
					win_q[r][0] <= win_q[r][1];
					win_q[r][1] <= win_q[r][2];
				end
				win_q[0][2] <= up;
				win_q[1][2] <= mid;
				win_q[2][2] <= tick_s1.cur;
				emit_s2     <= tick_s1.emit;
				last_s2     <= tick_s1.last;
				row_ok_s2   <= tick_s1.row_ok;
				col_ok_s2   <= tick_s1.col_ok;
			end
		end
	end

	always_comb begin
		// neighbors outside the image take the neutral value
		fill = (op == OP_DILATE) ? '0 : '1;
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 3; c++)
				cellv[r][c] = (row_ok_s2[r] && col_ok_s2[c]) ? win_q[r][c] : fill;
		for (int r = 0; r < 3; r++)
			rowv[r] = pick(pick(cellv[r][0], cellv[r][1], op), cellv[r][2], op);
		acc = pick(pick(rowv[0], rowv[1], op), rowv[2], op);
		push = valid_s2 && emit_s2;
		push_data.result_value  = acc;
		push_data.last_of_frame = last_s2;
	end

endmodule

`default_nettype wire

FILE: rtl/gm3_out_fifo.sv
// Small result queue between the window and the output channel.
// Holds finished results while the receiver stalls. Uses gm3_pkg.
`default_nettype none

module gm3_out_fifo
	import gm3_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	input  wire result_out_t           push_data,
	input  wire logic                  pop,
	output logic                       valid,
	output result_out_t                data,
	output logic      [FIFO_CNT_W-1:0] count
);

	result_out_t           fifo_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + FIFO_CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - FIFO_CNT_W'(1);
		end
	end

	assign valid = (cnt_q != '0);
	assign data  = fifo_q[rd_ptr_q];
	assign count = cnt_q;

endmodule

`default_nettype wire

FILE: rtl/gray_morphology_3x3.sv
// Top level of the 3x3 gray erosion / dilation block.
// Uses gm3_pkg, gm3_ctrl, gm3_line_store, gm3_window and gm3_out_fifo.
//
//   channel | signals                          | request moves
//   --------+----------------------------------+-------------------------------
//   in      | in_valid, in_stall, in_data      | pixel or flush tick
//   out     | out_valid, out_stall, out_data   | min/max result, last flag
//   cfg     | cfg_valid, cfg_ready, cfg_index, | register write (width,
//           | cfg_data                         | height, operation)
//
// One input request per cycle while in_stall is low; a result is made by the tick that
// completes its window, W+1 counted ticks after its own pixel, via the window registers and result queue.
// The line store is one RAM read and written once per tick, column address.
// Reset clears counters and queues; the line store needs no clearing pass.
// in_stall rises when the 4-entry result queue plus ticks in flight could
// overflow; cfg writes are taken at any time.
`default_nettype none

module gray_morphology_3x3
	import gm3_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire pixel_in_t        in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output result_out_t           out_data,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	localparam int SUM_W = FIFO_CNT_W + 1;

	logic                  in_fire;
	logic                  rd_en;
	logic [COL_W-1:0]      rd_addr;
	logic [RAM_W-1:0]      rd_data;
	tick_t                 tick_s1;
	op_t                   op;
	logic                  valid_s2;
	logic                  push;
	result_out_t           push_data;
	logic                  pop;
	logic [FIFO_CNT_W-1:0] fifo_count;
	logic [SUM_W-1:0]      pending;

	assign cfg_ready = 1'b1;
	assign in_fire   = in_valid && !in_stall;
	assign pop       = out_valid && !out_stall;

	// every tick in flight may still land in the queue
	assign pending  = SUM_W'(fifo_count) + SUM_W'(tick_s1.valid) + SUM_W'(valid_s2);
	assign in_stall = pending > SUM_W'(FIFO_DEPTH - 1);

	gm3_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_fire   (in_fire),
		.in_data   (in_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.tick_s1   (tick_s1),
		.op        (op)
	);

	// upper row gets the old lower pixel, lower row the current one
	gm3_line_store u_line_store (
		.clk   (clk),
		.we    (tick_s1.valid),
		.waddr (tick_s1.col),
		.wdata ({rd_data[PIX_W-1:0], tick_s1.cur}),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	gm3_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_s1   (tick_s1),
		.up        (rd_data[RAM_W-1:PIX_W]),
		.mid       (rd_data[PIX_W-1:0]),
		.op        (op),
		.valid_s2  (valid_s2),
		.push      (push),
		.push_data (push_data)
	);

	gm3_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.valid     (out_valid),
		.data      (out_data),
		.count     (fifo_count)
	);

endmodule

`default_nettype wire

FILE: rtl/gm3_checker.sv
// Port-level checks for gray_morphology_3x3, bound to the top level.
// Sees the top-level ports only. Uses gm3_pkg.
`default_nettype none

module gm3_checker
	import gm3_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_stall,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire result_out_t      out_data,
	input wire logic             cfg_valid,
	input wire logic             cfg_ready
);

	logic [31:0] in_cnt_q;
	logic [31:0] out_cnt_q;
	logic        in_fire;
	logic        out_fire;

	assign in_fire  = in_valid && !in_stall;
	assign out_fire = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_cnt_q  <= '0;
			out_cnt_q <= '0;
		end else begin
			if (in_fire)
				in_cnt_q <= in_cnt_q + 32'd1;
			if (out_fire)
				out_cnt_q <= out_cnt_q + 32'd1;
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");

	// with nothing queued the input side must not stall
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty result queue");

	// every result needs an earlier request behind it
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_fire |-> in_cnt_q > out_cnt_q)
		else $error("result without a preceding request");

	// configuration writes are never held off
	a_cfg_taken: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind gray_morphology_3x3 gm3_checker u_gm3_checker (.*);

`default_nettype wire
